>>> hw/rtl/adc_bma_pkg.sv
// Shared types and constants for the ADC block median / group average block
`timescale 1ns / 1ps

package adc_bma_pkg;

   localparam int VALUE_W  = 12;
   localparam int UNIT_W   = 1;
   localparam int CHAN_W   = 3;
   localparam int LIMIT_W  = 4;
   localparam int COUNT_W  = 8;
   localparam int MEAN_W   = 15;
   localparam int FRAC_W   = 3;
   localparam int PDATA_W  = 32;
   localparam int PADDR_W  = 3;

   localparam int BLOCK_SAMPLES_DEF = 128;
   localparam int GROUP_BLOCKS_DEF  = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   localparam logic [LIMIT_W-1:0] UNIT_ONE_RESET = 4'd5;
   localparam logic [LIMIT_W-1:0] UNIT_TWO_RESET = 4'd1;

   // register index, taken from paddr[2]
   typedef enum logic {
      REG_UNIT_ONE = 1'b0,
      REG_UNIT_TWO = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [VALUE_W-1:0] sample_value;
      logic [UNIT_W-1:0]  sample_unit;
      logic [CHAN_W-1:0]  sample_channel;
      logic               block_end;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] block_median;
      logic [COUNT_W-1:0] valid_samples;
      logic [COUNT_W-1:0] rejected_samples;
      logic               empty_block;
      logic               group_done;
      logic [MEAN_W-1:0]  group_mean;
   } rsp_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] unit_one_channels;
      logic [LIMIT_W-1:0] unit_two_channels;
   } cfg_type;

   typedef struct packed {
      logic take;
      logic setup;
      logic scan;
      logic decide;
      logic finish;
      logic div_step;
      logic reply;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic scan_last;
      logic bit_last;
      logic group_last;
   } status_type;

endpackage

>>> hw/rtl/adc_bma_csr.sv
// APB-style configuration registers: channel counts of both converter units
`timescale 1ns / 1ps

module adc_bma_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [adc_bma_pkg::PADDR_W-1:0]    paddr,
   input  logic [adc_bma_pkg::PDATA_W-1:0]    pwdata,
   output logic [adc_bma_pkg::PDATA_W-1:0]    prdata,
   output logic                               pready,
   output adc_bma_pkg::cfg_type               cfg
);

   adc_bma_pkg::cfg_type       cfg_ff, cfg_in;
   adc_bma_pkg::reg_index_type sel;
   logic                       wr_en;
   logic [adc_bma_pkg::LIMIT_W-1:0] rd_val;

   assign pready = 1'b1;
   assign sel    = adc_bma_pkg::reg_index_type'(paddr[2]);
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (sel)
            adc_bma_pkg::REG_UNIT_ONE:
               cfg_in.unit_one_channels = pwdata[adc_bma_pkg::LIMIT_W-1:0];
            adc_bma_pkg::REG_UNIT_TWO:
               cfg_in.unit_two_channels = pwdata[adc_bma_pkg::LIMIT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         adc_bma_pkg::REG_UNIT_ONE: rd_val = cfg_ff.unit_one_channels;
         adc_bma_pkg::REG_UNIT_TWO: rd_val = cfg_ff.unit_two_channels;
         default:                   rd_val = '0;
      endcase
   end

   assign prdata = {{(adc_bma_pkg::PDATA_W-adc_bma_pkg::LIMIT_W){1'b0}}, rd_val};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unit_one_channels <= adc_bma_pkg::UNIT_ONE_RESET;
         cfg_ff.unit_two_channels <= adc_bma_pkg::UNIT_TWO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/adc_bma_ctrl.sv
// Controller: sequences sample capture, radix median search, group divide and reply
`timescale 1ns / 1ps

module adc_bma_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_last,
   input  adc_bma_pkg::status_type status,
   output adc_bma_pkg::cmd_type    cmd,
   output logic                    busy
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SETUP  = 8'b0000_0010,
      ST_SCAN   = 8'b0000_0100,
      ST_DRAIN  = 8'b0000_1000,
      ST_DECIDE = 8'b0001_0000,
      ST_FINISH = 8'b0010_0000,
      ST_DIVIDE = 8'b0100_0000,
      ST_REPLY  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      take;

   assign busy = (state_ff != ST_IDLE);
   assign take = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (take && req_last) state_in = ST_SETUP;
         ST_SETUP:  state_in = status.empty ? ST_FINISH : ST_SCAN;
         ST_SCAN:   if (status.scan_last) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_DECIDE;
         ST_DECIDE: state_in = status.bit_last ? ST_FINISH : ST_SCAN;
         ST_FINISH: state_in = status.group_last ? ST_DIVIDE : ST_REPLY;
         ST_DIVIDE: state_in = ST_REPLY;
         ST_REPLY:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.take     = take;
      cmd.setup    = (state_ff == ST_SETUP);
      cmd.scan     = (state_ff == ST_SCAN);
      cmd.decide   = (state_ff == ST_DECIDE);
      cmd.finish   = (state_ff == ST_FINISH);
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.reply    = (state_ff == ST_REPLY);
   end

endmodule

>>> hw/rtl/adc_bma_datapath.sv
// Datapath: sample store, block counters, bitwise median select, group sum and divider
`timescale 1ns / 1ps

module adc_bma_datapath #(
   parameter int BLOCK_SAMPLES = adc_bma_pkg::BLOCK_SAMPLES_DEF,
   parameter int GROUP_BLOCKS  = adc_bma_pkg::GROUP_BLOCKS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  adc_bma_pkg::req_type    req,
   input  adc_bma_pkg::cfg_type    cfg,
   input  adc_bma_pkg::cmd_type    cmd,
   output adc_bma_pkg::status_type status,
   output adc_bma_pkg::rsp_type    rsp
);

   localparam int VALUE_W = adc_bma_pkg::VALUE_W;
   localparam int COUNT_W = adc_bma_pkg::COUNT_W;
   localparam int MEAN_W  = adc_bma_pkg::MEAN_W;
   localparam int ADDR_W  = $clog2(BLOCK_SAMPLES);
   localparam int CNT_W   = $clog2(BLOCK_SAMPLES + 1);
   localparam int GIDX_W  = $clog2(GROUP_BLOCKS);
   localparam int SUM_W   = VALUE_W + GIDX_W;
   localparam int DIV_W   = SUM_W + adc_bma_pkg::FRAC_W;
   localparam int SHIFT   = DIV_W + GIDX_W;
   localparam int PROD_W  = 2 * DIV_W + 1;

   // ceil(2^SHIFT / GROUP_BLOCKS): exact floor division for any DIV_W-bit dividend
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(GROUP_BLOCKS) - 64'd1) / 64'(GROUP_BLOCKS);

   localparam logic [CNT_W-1:0]  STORE_FULL = CNT_W'(BLOCK_SAMPLES);
   localparam logic [GIDX_W-1:0] GIDX_LAST  = GIDX_W'(GROUP_BLOCKS - 1);
   localparam logic [DIV_W:0]    RECIP      = (DIV_W+1)'(RECIP_FULL);

   // sample store
   logic [VALUE_W-1:0] mem [BLOCK_SAMPLES];
   logic [VALUE_W-1:0] rd_data_ff;

   // block counters and group state
   logic [CNT_W-1:0]   valid_cnt_ff, valid_cnt_in;
   logic [COUNT_W-1:0] reject_cnt_ff, reject_cnt_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [GIDX_W-1:0]  gidx_ff, gidx_in;

   // median search
   logic [ADDR_W-1:0]  addr_ff;
   logic               rd_valid_ff;
   logic [VALUE_W-1:0] prefix_ff, mask_ff, bit_sel_ff;
   logic [CNT_W-1:0]   rank_ff, match_cnt_ff;

   // divider
   logic [DIV_W-1:0]   dividend_ff;
   logic [MEAN_W-1:0]  quo_ff;
   logic [PROD_W-1:0]  product;

   // results
   logic [VALUE_W-1:0] out_median_ff;
   logic [COUNT_W-1:0] out_valid_ff, out_reject_ff;
   logic               out_empty_ff, out_done_ff;

   logic [adc_bma_pkg::LIMIT_W-1:0] limit;
   logic                            sample_ok, full, store_wr, match;
   logic [SUM_W-1:0]                sum_next;
   logic [CNT_W+COUNT_W-1:0]        valid_wide;
   logic [COUNT_W-1:0]              valid_sat;

   assign limit     = req.sample_unit[0] ? cfg.unit_two_channels : cfg.unit_one_channels;
   assign sample_ok = {1'b0, req.sample_channel} < limit;
   assign full      = (valid_cnt_ff == STORE_FULL);
   assign store_wr  = cmd.take && sample_ok && !full;

   assign match = ((rd_data_ff & mask_ff) == prefix_ff) && ((rd_data_ff & bit_sel_ff) == '0);

   assign sum_next = sum_ff + {{GIDX_W{1'b0}}, prefix_ff};
   assign product  = PROD_W'(dividend_ff) * PROD_W'(RECIP);

   assign valid_wide = {{COUNT_W{1'b0}}, valid_cnt_ff};
   assign valid_sat  = (valid_wide > (CNT_W+COUNT_W)'(adc_bma_pkg::COUNT_MAX))
                       ? adc_bma_pkg::COUNT_MAX : valid_wide[COUNT_W-1:0];

   always_comb begin
      valid_cnt_in  = valid_cnt_ff;
      reject_cnt_in = reject_cnt_ff;
      sum_in        = sum_ff;
      gidx_in       = gidx_ff;
      if (cmd.take) begin
         if (sample_ok) begin
            if (!full) valid_cnt_in = valid_cnt_ff + 1'b1;
         end else if (reject_cnt_ff != adc_bma_pkg::COUNT_MAX) begin
            reject_cnt_in = reject_cnt_ff + 1'b1;
         end
      end
      if (cmd.finish) begin
         valid_cnt_in  = '0;
         reject_cnt_in = '0;
         if (gidx_ff == GIDX_LAST) begin
            sum_in  = '0;
            gidx_in = '0;
         end else begin
            sum_in  = sum_next;
            gidx_in = gidx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_cnt_ff  <= '0;
         reject_cnt_ff <= '0;
         sum_ff        <= '0;
         gidx_ff       <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         valid_cnt_ff  <= valid_cnt_in;
         reject_cnt_ff <= reject_cnt_in;
         sum_ff        <= sum_in;
         gidx_ff       <= gidx_in;
         rd_valid_ff   <= cmd.scan;
      end
   end

   // store port: one write on capture, one registered read during the scan
   always_ff @(posedge clock) begin
      if (store_wr) mem[valid_cnt_ff[ADDR_W-1:0]] <= req.sample_value;
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) rd_data_ff <= mem[addr_ff];
   end

   // radix select: each pass counts samples matching the decided prefix with
   // the current bit clear, then fixes that bit of the median
   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         prefix_ff    <= '0;
         mask_ff      <= '0;
         bit_sel_ff   <= {1'b1, {(VALUE_W-1){1'b0}}};
         rank_ff      <= valid_cnt_ff >> 1;
         match_cnt_ff <= '0;
         addr_ff      <= '0;
      end else if (cmd.decide) begin
         mask_ff      <= mask_ff | bit_sel_ff;
         bit_sel_ff   <= bit_sel_ff >> 1;
         match_cnt_ff <= '0;
         addr_ff      <= '0;
         if (rank_ff >= match_cnt_ff) begin
            prefix_ff <= prefix_ff | bit_sel_ff;
            rank_ff   <= rank_ff - match_cnt_ff;
         end
      end else begin
         if (cmd.scan) addr_ff <= addr_ff + 1'b1;
         if (rd_valid_ff && match) match_cnt_ff <= match_cnt_ff + 1'b1;
      end
   end

   // sum*8 over the group size: dividend registered on finish, reciprocal
   // multiply in the following cycle
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         dividend_ff <= {sum_next, {adc_bma_pkg::FRAC_W{1'b0}}};
      end else if (cmd.div_step) begin
         quo_ff <= product[SHIFT +: MEAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_median_ff <= prefix_ff;
         out_valid_ff  <= valid_sat;
         out_reject_ff <= reject_cnt_ff;
         out_empty_ff  <= (valid_cnt_ff == '0);
         out_done_ff   <= (gidx_ff == GIDX_LAST);
      end
   end

   assign status.empty      = (valid_cnt_ff == '0);
   assign status.scan_last  = ({{(CNT_W-ADDR_W){1'b0}}, addr_ff} == valid_cnt_ff - 1'b1);
   assign status.bit_last   = bit_sel_ff[0];
   assign status.group_last = (gidx_ff == GIDX_LAST);

   assign rsp.block_median     = out_median_ff;
   assign rsp.valid_samples    = out_valid_ff;
   assign rsp.rejected_samples = out_reject_ff;
   assign rsp.empty_block      = out_empty_ff;
   assign rsp.group_done       = out_done_ff;
   assign rsp.group_mean       = out_done_ff ? quo_ff : '0;

endmodule

>>> hw/rtl/adc_block_median_average.sv
// Top level: ADC block median with eight-block (group) average of the medians
`timescale 1ns / 1ps
//
// Requests carry one tagged ADC word on req_data and are taken when start is
// high and busy is low. A word whose channel is below its unit's channel
// count (psel/penable/pwrite register port) is stored while the store has
// room; others are counted as rejected. A word without block_end leaves busy
// low. A word with block_end closes the block: busy rises, the upper median
// is found by a bitwise search over the store, 12 passes over the n stored
// samples (one read port of the sample store per cycle), each pass a scan, a
// drain and a decide step; an empty block skips the search. A block that
// completes a group also computes the mean (a reciprocal multiply) in a
// divide step before the reply. The result appears on rsp_data with
// rsp_strobe high for exactly one cycle; busy falls in the cycle after the
// strobe. The receiver cannot hold results off, so rsp_data is valid only
// with the strobe. Synchronous reset returns the controller to idle, clears
// the block counts, median sum and group position, and restores the channel
// counts to five and one. The sample store needs no clearing: only entries
// written in the current block are read.
//
module adc_block_median_average #(
   parameter int BLOCK_SAMPLES = adc_bma_pkg::BLOCK_SAMPLES_DEF,
   parameter int GROUP_BLOCKS  = adc_bma_pkg::GROUP_BLOCKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  adc_bma_pkg::req_type            req_data,
   output logic                            rsp_strobe,
   output adc_bma_pkg::rsp_type            rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [adc_bma_pkg::PADDR_W-1:0] paddr,
   input  logic [adc_bma_pkg::PDATA_W-1:0] pwdata,
   output logic [adc_bma_pkg::PDATA_W-1:0] prdata,
   output logic                            pready
);

   adc_bma_pkg::cfg_type    cfg;
   adc_bma_pkg::cmd_type    cmd;
   adc_bma_pkg::status_type status;

   adc_bma_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   adc_bma_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_data.block_end),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   adc_bma_datapath #(
      .BLOCK_SAMPLES (BLOCK_SAMPLES),
      .GROUP_BLOCKS  (GROUP_BLOCKS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req    (req_data),
      .cfg    (cfg),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp_data)
   );

   assign rsp_strobe = cmd.reply;

   a_close_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.block_end) |=> busy)
      else $error("closing request did not start median search");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result strobe longer than one cycle");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.empty_block) |->
         (rsp_data.block_median == '0) && (rsp_data.valid_samples == '0))
      else $error("empty block reported non-zero median or count");

   a_mean_only_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.group_done) |-> (rsp_data.group_mean == '0))
      else $error("group mean given without group completion");

endmodule

>>> sim/adc_block_median_average_checker.sv
// Checker for the ADC block median block: predicts each block result and compares it
`timescale 1ns / 1ps

module adc_block_median_average_checker
   import adc_bma_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  req_type            req_data,
   input  logic               rsp_strobe,
   input  rsp_type            rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   input  logic [PDATA_W-1:0] prdata,
   output int                 failures,
   output int                 pending
);

   localparam int DEPTH = BLOCK_SAMPLES_DEF;
   localparam int GROUP = GROUP_BLOCKS_DEF;

   logic [LIMIT_W-1:0] unit_one_limit = UNIT_ONE_RESET;
   logic [LIMIT_W-1:0] unit_two_limit = UNIT_TWO_RESET;
   logic [VALUE_W-1:0] block_samples [DEPTH];
   int                 stored_count    = 0;
   int                 reject_count    = 0;
   int                 median_total    = 0;
   int                 blocks_in_group = 0;
   int                 error_total     = 0;
   rsp_type            block_results_q [$];

   function automatic logic [VALUE_W-1:0] upper_median(int n);
      logic [VALUE_W-1:0] ordered [DEPTH];
      logic [VALUE_W-1:0] v;
      int                 j;
      if (n == 0) return '0;
      for (int i = 0; i < n; i++) ordered[i] = block_samples[i];
      for (int i = 1; i < n; i++) begin
         v = ordered[i];
         j = i;
         while (j > 0 && ordered[j-1] > v) begin
            ordered[j] = ordered[j-1];
            j--;
         end
         ordered[j] = v;
      end
      return ordered[n/2];
   endfunction

   task automatic compare_field(string field, logic [31:0] expected, logic [31:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %0d, got %0d", field, expected, actual);
         error_total++;
      end
   endtask

   task automatic take_word(req_type w);
      rsp_type            r;
      logic [LIMIT_W-1:0] limit;
      logic [VALUE_W-1:0] med;
      limit = w.sample_unit ? unit_two_limit : unit_one_limit;
      if ({1'b0, w.sample_channel} < limit) begin
         // store full: further valid words are dropped uncounted
         if (stored_count < DEPTH) begin
            block_samples[stored_count] = w.sample_value;
            stored_count++;
         end
      end else if (reject_count < COUNT_MAX) begin
         reject_count++;
      end
      if (w.block_end) begin
         med = upper_median(stored_count);
         median_total += 32'(med);
         blocks_in_group++;
         r = '0;
         r.block_median     = med;
         r.valid_samples    = COUNT_W'(stored_count);
         r.rejected_samples = COUNT_W'(reject_count);
         r.empty_block      = (stored_count == 0);
         if (blocks_in_group >= GROUP) begin
            r.group_done    = 1'b1;
            r.group_mean    = MEAN_W'((median_total << FRAC_W) / GROUP);
            median_total    = 0;
            blocks_in_group = 0;
         end
         block_results_q.push_back(r);
         stored_count = 0;
         reject_count = 0;
      end
   endtask

   task automatic check_block_result();
      rsp_type e;
      if (block_results_q.size() == 0) begin
         $error("rsp_strobe with no block outstanding");
         error_total++;
      end else begin
         e = block_results_q.pop_front();
         compare_field("block_median", 32'(e.block_median), 32'(rsp_data.block_median));
         compare_field("valid_samples", 32'(e.valid_samples), 32'(rsp_data.valid_samples));
         compare_field("rejected_samples", 32'(e.rejected_samples),
                       32'(rsp_data.rejected_samples));
         compare_field("empty_block", 32'(e.empty_block), 32'(rsp_data.empty_block));
         compare_field("group_done", 32'(e.group_done), 32'(rsp_data.group_done));
         compare_field("group_mean", 32'(e.group_mean), 32'(rsp_data.group_mean));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         unit_one_limit  = UNIT_ONE_RESET;
         unit_two_limit  = UNIT_TWO_RESET;
         stored_count    = 0;
         reject_count    = 0;
         median_total    = 0;
         blocks_in_group = 0;
         block_results_q.delete();
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (reg_index_type'(paddr[2]))
                  REG_UNIT_ONE: unit_one_limit = pwdata[LIMIT_W-1:0];
                  REG_UNIT_TWO: unit_two_limit = pwdata[LIMIT_W-1:0];
               endcase
            end else begin
               compare_field("prdata",
                  32'((reg_index_type'(paddr[2]) == REG_UNIT_TWO) ? unit_two_limit
                                                                   : unit_one_limit),
                  prdata);
            end
         end
         if (rsp_strobe) check_block_result();
         if (start && !busy) take_word(req_data);
      end
      failures <= error_total;
      pending  <= block_results_q.size();
   end

endmodule

>>> sim/adc_block_median_average_test.sv
// Testbench top for adc_block_median_average: request stimulus, register setup and verdict
`timescale 1ns / 1ps

module adc_block_median_average_test;
   import adc_bma_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS   = 180;
   localparam int PHASES         = 6;
   localparam int QUIET_TAIL     = 80;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_data;
   logic               rsp_strobe;
   rsp_type            rsp_data;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   int                 failures;
   int                 pending;
   int                 words_sent  = 0;
   int                 idle_cycles = 0;
   int                 quiet_from  = 0;
   bit                 gaps_on     = 1'b0;
   logic [LIMIT_W-1:0] one_limit   = UNIT_ONE_RESET;
   logic [LIMIT_W-1:0] two_limit   = UNIT_TWO_RESET;

   adc_block_median_average i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   adc_block_median_average_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // any request, block result or register access counts as progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_word(logic [VALUE_W-1:0] value, logic unit,
                                         logic [CHAN_W-1:0] chan, logic is_last);
      req_type w;
      w.sample_value   = value;
      w.sample_unit    = unit;
      w.sample_channel = chan;
      w.block_end      = is_last;
      return w;
   endfunction

   task automatic send_word(req_type w);
      int gap;
      @(negedge clock);
      start    = 1'b1;
      req_data = w;
      do @(posedge clock); while (busy);
      words_sent++;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         start    = 1'b0;
         req_data = make_word(VALUE_W'($urandom), 1'($urandom), CHAN_W'($urandom),
                              1'($urandom));
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // stop requesting and let every outstanding block result arrive
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(logic write, reg_index_type idx, logic [LIMIT_W-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = write;
      paddr   = {idx, 2'b00};
      pwdata  = $urandom;
      pwdata[LIMIT_W-1:0] = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic send_random_block();
      int                 length;
      int                 pick;
      logic               unit;
      logic [CHAN_W-1:0]  chan;
      logic [VALUE_W-1:0] value;
      logic [LIMIT_W-1:0] limit;
      pick = $urandom_range(0, 99);
      if (pick < 70)      length = $urandom_range(1, 8);
      else if (pick < 95) length = $urandom_range(9, 40);
      else                length = $urandom_range(41, 140);
      gaps_on = ($urandom_range(0, 1) == 1) && (words_sent < quiet_from);
      for (int i = 0; i < length; i++) begin
         unit  = 1'($urandom);
         limit = unit ? two_limit : one_limit;
         // lean towards accepted channels so the blocks carry real data
         if (limit != 0 && $urandom_range(0, 3) != 0)
            chan = CHAN_W'($urandom_range(0, (limit > 8) ? 7 : limit - 1));
         else
            chan = CHAN_W'($urandom);
         case ($urandom_range(0, 9))
            0:       value = '0;
            1:       value = '1;
            2, 3:    value = VALUE_W'($urandom_range(0, 3) * 1365);
            default: value = VALUE_W'($urandom);
         endcase
         send_word(make_word(value, unit, chan, i == length - 1));
      end
   endtask

   initial begin
      int phase_end;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_access(1'b0, REG_UNIT_ONE, '0);
      csr_access(1'b0, REG_UNIT_TWO, '0);

      // directed blocks under the reset channel counts (five and one)
      gaps_on = 1'b1;
      send_word(make_word(12'd4095, 1'b0, 3'd0, 1'b1));
      send_word(make_word(12'd0,    1'b0, 3'd7, 1'b1));   // empty block
      send_word(make_word(12'd0,    1'b0, 3'd4, 1'b0));
      send_word(make_word(12'd4095, 1'b1, 3'd0, 1'b0));
      send_word(make_word(12'd2048, 1'b0, 3'd0, 1'b0));
      send_word(make_word(12'd1,    1'b0, 3'd3, 1'b1));
      send_word(make_word(12'd100,  1'b1, 3'd1, 1'b0));   // rejected on unit two
      send_word(make_word(12'd200,  1'b0, 3'd5, 1'b0));   // rejected on unit one
      send_word(make_word(12'd300,  1'b1, 3'd0, 1'b1));
      send_word(make_word(12'd7,    1'b0, 3'd1, 1'b0));   // ties in the sort
      send_word(make_word(12'd7,    1'b0, 3'd2, 1'b0));
      send_word(make_word(12'd7,    1'b0, 3'd3, 1'b0));
      send_word(make_word(12'd3,    1'b0, 3'd0, 1'b1));
      send_word(make_word(12'd5,    1'b0, 3'd1, 1'b0));
      send_word(make_word(12'd1,    1'b0, 3'd2, 1'b0));
      send_word(make_word(12'd9,    1'b0, 3'd3, 1'b1));
      send_word(make_word(12'd4095, 1'b0, 3'd0, 1'b0));
      send_word(make_word(12'd4095, 1'b0, 3'd1, 1'b1));
      send_word(make_word(12'd0,    1'b0, 3'd6, 1'b1));   // eighth block closes the group

      // store overflow: more valid words than the store holds
      gaps_on = 1'b0;
      for (int i = 0; i < 135; i++)
         send_word(make_word(VALUE_W'($urandom), 1'b0, CHAN_W'($urandom_range(0, 4)),
                             i == 134));
      // reject count saturation
      for (int i = 0; i < 262; i++) begin
         if (i % 50 == 10)
            send_word(make_word(VALUE_W'($urandom), 1'b0, CHAN_W'($urandom_range(0, 4)),
                                1'b0));
         else
            send_word(make_word(VALUE_W'($urandom), i[0],
                                CHAN_W'(i[0] ? $urandom_range(1, 7) : $urandom_range(5, 7)),
                                i == 261));
      end
      drain();

      quiet_from = words_sent + RANDOM_ITEMS - QUIET_TAIL;
      phase_end  = words_sent;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       begin one_limit = 4'd0;  two_limit = 4'd0; end
            1:       begin one_limit = 4'd8;  two_limit = 4'd8; end
            2:       begin one_limit = 4'd15; two_limit = 4'd9; end
            3:       begin one_limit = 4'd3;  two_limit = 4'd6; end
            default: begin one_limit = LIMIT_W'($urandom); two_limit = LIMIT_W'($urandom); end
         endcase
         csr_access(1'b1, REG_UNIT_ONE, one_limit);
         csr_access(1'b1, REG_UNIT_TWO, two_limit);
         csr_access(1'b0, REG_UNIT_ONE, '0);
         csr_access(1'b0, REG_UNIT_TWO, '0);
         phase_end += RANDOM_ITEMS / PHASES;
         while (words_sent < phase_end) send_random_block();
         drain();
      end

      repeat (40) @(posedge clock);
      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
